// ===== src/gfq_pkg.sv =====
// Package for the guarded frame transmit queue: codes, reset values and enums.
// No dependencies; every other file of the block but gfq_cmd_fifo refers to it by scoped names.
package gfq_pkg;

  // input item codes
  typedef enum logic [1:0] {
    ACT_TICK = 2'd0,
    ACT_RX   = 2'd1,
    ACT_BYTE = 2'd2
  } action_e;

  // enqueue status, also the drop state of the frame being loaded
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_LONG = 2'd2
  } enq_status_e;

  typedef enum logic {
    KIND_TX     = 1'b0,
    KIND_STATUS = 1'b1
  } kind_e;

  // operations passed from the front to the back
  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_SEND = 1'b1
  } cmd_op_e;

  // configuration register indexes
  localparam logic [1:0] CFG_RX_GUARD = 2'd0;
  localparam logic [1:0] CFG_TX_GAP   = 2'd1;

  localparam int unsigned MS_W = 10;
  localparam logic [MS_W-1:0] RX_GUARD_RESET = 10'd30;
  localparam logic [MS_W-1:0] TX_GAP_RESET   = 10'd10;
  localparam logic [MS_W-1:0] MS_MAX         = 10'd1023;

endpackage

// ===== src/gfq_if.sv =====
// Handshake interfaces of the guarded frame transmit queue: input, result, config.
// Depends on gfq_pkg for the millisecond counter width.
interface gfq_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] data_byte;
  logic       frame_end;
  modport source (output valid, action, data_byte, frame_end, input ready);
  modport sink   (input valid, action, data_byte, frame_end, output ready);
endinterface

interface gfq_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] tx_byte;
  logic       tx_last;
  logic [1:0] enqueue_status;
  modport source (output valid, kind, tx_byte, tx_last, enqueue_status, input ready);
  modport sink   (input valid, kind, tx_byte, tx_last, enqueue_status, output ready);
endinterface

interface gfq_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                index;
  logic [gfq_pkg::MS_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/gfq_front.sv =====
// Front end: takes input and config transactions, keeps queue bookkeeping and
// timers, and issues store writes, status and send commands. Uses gfq_pkg, gfq_if.
module gfq_front #(
  parameter int unsigned QUEUE_DEPTH     = 4,
  parameter int unsigned MAX_FRAME_BYTES = 17,
  parameter int unsigned ADDR_W          = 7,
  parameter int unsigned LEN_W           = 5,
  parameter type         cmd_t           = logic
) (
  input  logic clk_i,
  input  logic rst_ni,
  gfq_in_if.sink  in_i,
  gfq_cfg_if.sink cfg_i,
  input  logic    cmd_full_i,
  output logic    cmd_push_o,
  output cmd_t    cmd_o
);

  localparam int unsigned SLOT_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned HELD_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned MS_W   = gfq_pkg::MS_W;

  logic [SLOT_W-1:0]  head_q, head_d, tail_q, tail_d;
  logic [HELD_W-1:0]  held_q, held_d;
  logic [LEN_W-1:0]   fill_q, fill_d;
  gfq_pkg::enq_status_e drop_q, drop_d;
  logic [MS_W-1:0]    rx_ms_q, rx_ms_d, tx_ms_q, tx_ms_d;
  logic [MS_W-1:0]    guard_q, gap_q;
  logic [LEN_W-1:0]   len_q [QUEUE_DEPTH];
  logic               len_we;

  logic               accept;
  logic [MS_W-1:0]    rx_inc, tx_inc;
  gfq_pkg::enq_status_e drop_v;
  logic               wr_v;

  assign in_i.ready  = !cmd_full_i;
  assign cfg_i.ready = 1'b1;
  assign accept      = in_i.valid && in_i.ready;

  assign rx_inc = (rx_ms_q == gfq_pkg::MS_MAX) ? rx_ms_q : rx_ms_q + 1'b1;
  assign tx_inc = (tx_ms_q == gfq_pkg::MS_MAX) ? tx_ms_q : tx_ms_q + 1'b1;

  always_comb begin
    head_d     = head_q;
    tail_d     = tail_q;
    held_d     = held_q;
    fill_d     = fill_q;
    drop_d     = drop_q;
    rx_ms_d    = rx_ms_q;
    tx_ms_d    = tx_ms_q;
    len_we     = 1'b0;
    cmd_push_o = 1'b0;
    cmd_o      = '0;
    drop_v     = drop_q;
    wr_v       = 1'b0;
    if (accept) begin
      case (gfq_pkg::action_e'(in_i.action))
        gfq_pkg::ACT_TICK: begin
          rx_ms_d = rx_inc;
          tx_ms_d = tx_inc;
          if (held_q != '0 && rx_inc >= guard_q && tx_inc >= gap_q) begin
            cmd_push_o = 1'b1;
            cmd_o.op   = gfq_pkg::OP_SEND;
            cmd_o.addr = ADDR_W'(head_q) * ADDR_W'(MAX_FRAME_BYTES);
            cmd_o.len  = len_q[head_q];
            head_d     = (head_q == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
            held_d     = held_q - 1'b1;
            tx_ms_d    = '0;
          end
        end
        gfq_pkg::ACT_RX: begin
          rx_ms_d = '0;
        end
        gfq_pkg::ACT_BYTE: begin
          // fullness is judged only at the first byte of a frame
          if (fill_q == '0 && drop_q == gfq_pkg::ST_OK &&
              held_q >= HELD_W'(QUEUE_DEPTH)) begin
            drop_v = gfq_pkg::ST_FULL;
          end
          if (fill_q >= LEN_W'(MAX_FRAME_BYTES)) begin
            drop_v = gfq_pkg::ST_LONG;
          end else begin
            wr_v   = (drop_v == gfq_pkg::ST_OK);
            fill_d = fill_q + 1'b1;
          end
          cmd_o.op         = gfq_pkg::OP_BYTE;
          cmd_o.wr_en      = wr_v;
          cmd_o.addr       = ADDR_W'(tail_q) * ADDR_W'(MAX_FRAME_BYTES) + ADDR_W'(fill_q);
          cmd_o.data       = in_i.data_byte;
          cmd_o.has_status = in_i.frame_end;
          cmd_o.status     = drop_v;
          cmd_push_o       = wr_v || in_i.frame_end;
          drop_d           = drop_v;
          if (in_i.frame_end) begin
            if (drop_v == gfq_pkg::ST_OK) begin
              len_we = 1'b1;
              tail_d = (tail_q == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
              held_d = held_q + 1'b1;
            end
            fill_d = '0;
            drop_d = gfq_pkg::ST_OK;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      held_q  <= '0;
      fill_q  <= '0;
      drop_q  <= gfq_pkg::ST_OK;
      rx_ms_q <= '0;
      tx_ms_q <= '0;
      guard_q <= gfq_pkg::RX_GUARD_RESET;
      gap_q   <= gfq_pkg::TX_GAP_RESET;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      held_q  <= held_d;
      fill_q  <= fill_d;
      drop_q  <= drop_d;
      rx_ms_q <= rx_ms_d;
      tx_ms_q <= tx_ms_d;
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          gfq_pkg::CFG_RX_GUARD: guard_q <= cfg_i.data;
          gfq_pkg::CFG_TX_GAP:   gap_q   <= cfg_i.data;
          default: ;
        endcase
      end
    end
  end

  // frame lengths per slot, only read once committed
  always_ff @(posedge clk_i) begin
    if (len_we) begin
      len_q[tail_q] <= fill_d == '0 ? fill_q + 1'b1 : fill_d;
    end
  end

endmodule

// ===== src/gfq_cmd_fifo.sv =====
// Short command queue between the front and back ends of the frame queue.
// Generic over the command type; no package dependency.
module gfq_cmd_fifo #(
  parameter int unsigned DEPTH = 4,
  parameter type         cmd_t = logic
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  input  logic pop_i,
  output cmd_t data_o,
  output logic full_o,
  output logic empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t              slot_q [DEPTH];
  logic [PTR_W-1:0]  wr_q, rd_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slot_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== src/gfq_back.sv =====
// Back end: frame byte store, command sequencer and registered result stage.
// Uses gfq_pkg and the result interface from gfq_if.
module gfq_back #(
  parameter int unsigned STORE_DEPTH = 68,
  parameter int unsigned ADDR_W      = 7,
  parameter int unsigned LEN_W       = 5,
  parameter type         cmd_t       = logic
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t cmd_i,
  input  logic cmd_empty_i,
  output logic cmd_pop_o,
  gfq_out_if.source res_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EMIT
  } state_e;

  state_e             state_q;
  logic [ADDR_W-1:0]  rd_addr_q;
  logic [LEN_W-1:0]   left_q;
  logic [7:0]         rd_data_q;
  logic [7:0]         store [STORE_DEPTH];

  logic               out_valid_q, out_kind_q, out_last_q;
  logic [7:0]         out_byte_q;
  logic [1:0]         out_status_q;

  logic               out_free;
  logic               wr_en, rd_en;
  logic               load_res;

  assign out_free = !out_valid_q || res_o.ready;

  // a status command waits until the result stage is free
  assign cmd_pop_o = (state_q == S_IDLE) && !cmd_empty_i &&
                     !(cmd_i.op == gfq_pkg::OP_BYTE && cmd_i.has_status && !out_free);
  assign wr_en     = cmd_pop_o && cmd_i.op == gfq_pkg::OP_BYTE && cmd_i.wr_en;
  assign rd_en     = (state_q == S_READ);

  // result register takes a new transaction this cycle
  assign load_res  = (cmd_pop_o && cmd_i.op == gfq_pkg::OP_BYTE && cmd_i.has_status) ||
                     (state_q == S_EMIT && out_free);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store[cmd_i.addr] <= cmd_i.data;
    end
    if (rd_en) begin
      rd_data_q <= store[rd_addr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      rd_addr_q    <= '0;
      left_q       <= '0;
      out_valid_q  <= 1'b0;
      out_kind_q   <= gfq_pkg::KIND_TX;
      out_byte_q   <= '0;
      out_last_q   <= 1'b0;
      out_status_q <= gfq_pkg::ST_OK;
    end else begin
      if (load_res) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (cmd_pop_o) begin
            if (cmd_i.op == gfq_pkg::OP_SEND) begin
              rd_addr_q <= cmd_i.addr;
              left_q    <= cmd_i.len;
              state_q   <= S_READ;
            end else if (cmd_i.has_status) begin
              out_kind_q   <= gfq_pkg::KIND_STATUS;
              out_byte_q   <= '0;
              out_last_q   <= 1'b0;
              out_status_q <= cmd_i.status;
            end
          end
        end
        S_READ: begin
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_kind_q   <= gfq_pkg::KIND_TX;
            out_byte_q   <= rd_data_q;
            out_last_q   <= (left_q == LEN_W'(1));
            out_status_q <= gfq_pkg::ST_OK;
            left_q       <= left_q - 1'b1;
            rd_addr_q    <= rd_addr_q + 1'b1;
            state_q      <= (left_q == LEN_W'(1)) ? S_IDLE : S_READ;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.kind           = out_kind_q;
  assign res_o.tx_byte        = out_byte_q;
  assign res_o.tx_last        = out_last_q;
  assign res_o.enqueue_status = out_status_q;

endmodule

// ===== src/guarded_frame_tx_queue_unit.sv =====
// Top level of the guarded frame transmit queue: front end, command queue, back end.
// Depends on gfq_pkg, gfq_if, gfq_front, gfq_cmd_fifo and gfq_back.
//
// Holds up to QUEUE_DEPTH transmit frames of 1 to MAX_FRAME_BYTES bytes, loaded one
// byte per input transaction (action 2, frame_end on the last byte). Each completed
// frame yields one status result: accepted, dropped as the queue was full at its
// first byte, or dropped as too long (too long wins). Action 1 marks receive
// activity; action 0 is the millisecond tick, which advances both saturating
// elapsed counters and releases the head frame, byte by byte with tx_last on the
// final one, once ms_since_rx >= rx_guard_ms and ms_since_tx >= tx_gap_ms.
// Flow: every input transaction is taken by the front end while the four-entry
// command queue has room. Each frame byte sent passes through a registered read of
// the single-port byte store, then the result register, and the back end takes no
// new command until the last byte of a released frame is sent; the command queue is
// what lets further input flow meanwhile. The result register decouples the result
// channel from the block. The byte store has no reset and no clearing pass: only
// bytes written for a frame are ever read back. Configuration (index 0 rx_guard_ms,
// index 1 tx_gap_ms, others ignored) is always ready and should be written only
// while the block is idle.
module guarded_frame_tx_queue_unit #(
  parameter int unsigned QUEUE_DEPTH     = 4,
  parameter int unsigned MAX_FRAME_BYTES = 17
) (
  input  logic clk_i,
  input  logic rst_ni,
  gfq_in_if.sink    in_i,
  gfq_cfg_if.sink   cfg_i,
  gfq_out_if.source res_o
);

  localparam int unsigned STORE_DEPTH = QUEUE_DEPTH * MAX_FRAME_BYTES;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam int unsigned LEN_W       = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned CMD_DEPTH   = 4;

  // one command: a byte write and/or a status, or a frame send
  typedef struct packed {
    gfq_pkg::cmd_op_e     op;
    logic                 wr_en;
    logic [ADDR_W-1:0]    addr;
    logic [7:0]           data;
    logic                 has_status;
    gfq_pkg::enq_status_e status;
    logic [LEN_W-1:0]     len;
  } cmd_t;

  cmd_t cmd_push_data, cmd_pop_data;
  logic cmd_push, cmd_pop, cmd_full, cmd_empty;

  gfq_front #(
    .QUEUE_DEPTH    (QUEUE_DEPTH),
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES),
    .ADDR_W         (ADDR_W),
    .LEN_W          (LEN_W),
    .cmd_t          (cmd_t)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .cfg_i     (cfg_i),
    .cmd_full_i(cmd_full),
    .cmd_push_o(cmd_push),
    .cmd_o     (cmd_push_data)
  );

  gfq_cmd_fifo #(
    .DEPTH(CMD_DEPTH),
    .cmd_t(cmd_t)
  ) u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .data_i (cmd_push_data),
    .pop_i  (cmd_pop),
    .data_o (cmd_pop_data),
    .full_o (cmd_full),
    .empty_o(cmd_empty)
  );

  gfq_back #(
    .STORE_DEPTH(STORE_DEPTH),
    .ADDR_W     (ADDR_W),
    .LEN_W      (LEN_W),
    .cmd_t      (cmd_t)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd_pop_data),
    .cmd_empty_i(cmd_empty),
    .cmd_pop_o  (cmd_pop),
    .res_o      (res_o)
  );

`ifndef ASSERT_OFF
  // the front must never issue a command into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_push |-> !cmd_full)
    else $error("command pushed into full queue");

  // status results carry no frame byte, frame bytes carry no status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.kind == gfq_pkg::KIND_STATUS |->
      res_o.tx_byte == '0 && !res_o.tx_last && res_o.enqueue_status != 2'd3)
    else $error("malformed status result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.kind == gfq_pkg::KIND_TX |->
      res_o.enqueue_status == gfq_pkg::ST_OK)
    else $error("frame byte result with status set");
`endif

endmodule
